@@ sv/abbt_pkg.sv @@
// Shared types and constants for the alpha bounding box trim block.
package abbt_pkg;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned PosW   = $clog2(MaxDim);
  localparam int unsigned DimW   = PosW + 1;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned OutW   = 80;

  localparam logic [DimW-1:0]   WidthRst     = DimW'(64);
  localparam logic [DimW-1:0]   HeightRst    = DimW'(64);
  localparam logic [AlphaW-1:0] ThresholdRst = AlphaW'(30);

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegImageWidth     = 2'd0;
  localparam logic [1:0] RegImageHeight    = 2'd1;
  localparam logic [1:0] RegAlphaThreshold = 2'd2;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [AlphaW-1:0] threshold;
  } cfg_t;

  // bounding box captured at the end of a frame
  typedef struct packed {
    logic            seen;
    logic [PosW-1:0] first_row;
    logic [PosW-1:0] last_row;
    logic [PosW-1:0] left_col;
    logic [PosW-1:0] right_col;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } box_t;

  typedef struct packed {
    logic [DimW-1:0] crop_height;
    logic [DimW-1:0] crop_width;
    logic [PosW-1:0] trim_right;
    logic [PosW-1:0] trim_left;
    logic [PosW-1:0] trim_bottom;
    logic [PosW-1:0] trim_top;
  } trim_res_t;

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ sv/abbt_cfg.sv @@
// APB register file holding image size and alpha threshold.
module abbt_cfg import abbt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [DimW-1:0]   width_q, width_d;
  logic [DimW-1:0]   height_q, height_d;
  logic [AlphaW-1:0] thr_q, thr_d;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    thr_d    = thr_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegImageWidth:     width_d  = pwdata[DimW-1:0];
        RegImageHeight:    height_d = pwdata[DimW-1:0];
        RegAlphaThreshold: thr_d    = pwdata[AlphaW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      thr_q    <= ThresholdRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      thr_q    <= thr_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegImageWidth:     prdata = 32'(width_q);
      RegImageHeight:    prdata = 32'(height_q);
      RegAlphaThreshold: prdata = 32'(thr_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.width     = eff_dim(width_q);
  assign cfg_o.height    = eff_dim(height_q);
  assign cfg_o.threshold = thr_q;

endmodule

@@ sv/abbt_track.sv @@
// Raster counters, opaque bounding box trackers and end-of-frame snapshot register.
module abbt_track import abbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              pix_valid_i,
  input  logic [AlphaW-1:0] alpha_i,
  output logic              pix_ready_o,
  output logic              snap_valid_o,
  output box_t              snap_o,
  input  logic              snap_ready_i
);

  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic            seen_q, seen_d;
  logic [PosW-1:0] first_q, first_d, last_q, last_d;
  logic [PosW-1:0] left_q, left_d, right_q, right_d;
  logic            snap_valid_q, snap_valid_d;
  box_t            snap_q;

  logic            accept, opaque, col_end, row_end, frame_end;
  logic [PosW-1:0] first_u, last_u, left_u, right_u;

  assign pix_ready_o = !snap_valid_q || snap_ready_i;
  assign accept      = pix_valid_i && pix_ready_o;
  assign opaque      = alpha_i > cfg_i.threshold;

  // tracker values with the current pixel folded in
  assign first_u = (opaque && !seen_q) ? row_q : first_q;
  assign last_u  = opaque ? row_q : last_q;
  assign left_u  = (opaque && (col_q < left_q)) ? col_q : left_q;
  assign right_u = (opaque && (col_q > right_q)) ? col_q : right_q;

  // a width or height shrunk mid-frame ends the row or frame at once
  assign col_end   = ({1'b0, col_q} + DimW'(1)) >= cfg_i.width;
  assign row_end   = ({1'b0, row_q} + DimW'(1)) >= cfg_i.height;
  assign frame_end = col_end && row_end;

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    seen_d       = seen_q;
    first_d      = first_q;
    last_d       = last_q;
    left_d       = left_q;
    right_d      = right_q;
    snap_valid_d = snap_valid_q && !snap_ready_i;
    if (accept) begin
      if (frame_end) begin
        col_d        = '0;
        row_d        = '0;
        seen_d       = 1'b0;
        first_d      = '0;
        last_d       = '0;
        left_d       = '1;
        right_d      = '0;
        snap_valid_d = 1'b1;
      end else begin
        seen_d  = seen_q || opaque;
        first_d = first_u;
        last_d  = last_u;
        left_d  = left_u;
        right_d = right_u;
        col_d   = col_end ? '0 : col_q + PosW'(1);
        row_d   = col_end ? row_q + PosW'(1) : row_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      seen_q       <= 1'b0;
      first_q      <= '0;
      last_q       <= '0;
      left_q       <= '1;
      right_q      <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      seen_q       <= seen_d;
      first_q      <= first_d;
      last_q       <= last_d;
      left_q       <= left_d;
      right_q      <= right_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_end) begin
      snap_q.seen      <= seen_q || opaque;
      snap_q.first_row <= first_u;
      snap_q.last_row  <= last_u;
      snap_q.left_col  <= left_u;
      snap_q.right_col <= right_u;
      snap_q.width     <= cfg_i.width;
      snap_q.height    <= cfg_i.height;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

@@ sv/abbt_trim.sv @@
// Trim margin and crop size computation into the result register.
module abbt_trim import abbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      snap_valid_i,
  input  box_t      snap_i,
  output logic      snap_ready_o,
  output logic      res_valid_o,
  output trim_res_t res_o,
  input  logic      res_ready_i
);

  logic            res_valid_q, res_valid_d;
  trim_res_t       res_q, res_d;
  logic            load;
  logic [PosW-1:0] half_w, half_h, gap_b, gap_r;
  logic [PosW-1:0] top, bot, lft, rgt;
  logic [DimW-1:0] gap_b_full, gap_r_full;

  assign snap_ready_o = !res_valid_q || res_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  assign half_w = PosW'(snap_i.width >> 1);
  assign half_h = PosW'(snap_i.height >> 1);

  // distance to the far edge, zero when the position lies at or past it
  assign gap_b_full = snap_i.height - DimW'(1) - {1'b0, snap_i.last_row};
  assign gap_r_full = snap_i.width - DimW'(1) - {1'b0, snap_i.right_col};
  assign gap_b = (({1'b0, snap_i.last_row} + DimW'(1)) >= snap_i.height) ? '0
               : gap_b_full[PosW-1:0];
  assign gap_r = (({1'b0, snap_i.right_col} + DimW'(1)) >= snap_i.width) ? '0
               : gap_r_full[PosW-1:0];

  always_comb begin
    if (snap_i.seen) begin
      top = (snap_i.first_row < half_h) ? snap_i.first_row : half_h;
      bot = (gap_b < half_h) ? gap_b : half_h;
      lft = (snap_i.left_col < half_w) ? snap_i.left_col : half_w;
      rgt = (gap_r < half_w) ? gap_r : half_w;
    end else begin
      top = half_h;
      bot = half_h;
      lft = half_w;
      rgt = half_w;
    end
  end

  always_comb begin
    res_d.trim_top    = top;
    res_d.trim_bottom = bot;
    res_d.trim_left   = lft;
    res_d.trim_right  = rgt;
    res_d.crop_width  = snap_i.width - {1'b0, lft} - {1'b0, rgt};
    res_d.crop_height = snap_i.height - {1'b0, top} - {1'b0, bot};
    res_valid_d       = load || (res_valid_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/alpha_bounding_box_trim.sv @@
// Top level of the opaque pixel bounding box auto-crop block.
//
//  channel | dir | handshake                 | content
//  s_axis  | in  | s_axis_tvalid/tready      | alpha, one pixel in raster order
//  m_axis  | out | m_axis_tvalid/tready      | four trims and crop size, one per frame
//  apb     | in  | psel/penable/pwrite/pready| width 0x0, height 0x4, threshold 0x8
//
// One pixel per cycle while s_axis_tready is high; the per-pixel compare and min/max
// update run in the accept cycle. m_axis_tvalid rises once a frame's last pixel has
// passed the snapshot register and then the trim arithmetic into the result register.
// Reset clears counters and trackers and loads width 64, height 64, threshold 30.
// A stalled result holds the snapshot stage; pixels keep flowing until both hold one.
module alpha_bounding_box_trim import abbt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] alpha
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [11:0] trim_top, [23:12] trim_bottom, [35:24] trim_left, [47:36] trim_right,
  // [60:48] crop_width, [73:61] crop_height, [79:74] zero
  output logic [OutW-1:0]  m_axis_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t      cfg;
  box_t      snap;
  logic      snap_valid, snap_ready;
  trim_res_t res;

  abbt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  abbt_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pix_valid_i  (s_axis_tvalid),
    .alpha_i      (s_axis_tdata[AlphaW-1:0]),
    .pix_ready_o  (s_axis_tready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  abbt_trim u_trim (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = OutW'(res);

  // left and right trims plus crop width never exceed the maximum dimension
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((DimW+1)'(res.trim_left) + (DimW+1)'(res.trim_right)
                       + (DimW+1)'(res.crop_width)) <= (DimW+1)'(MaxDim))
    else $error("crop width plus trims exceeds maximum dimension");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> snap_valid && m_axis_tvalid)
    else $error("pixel input stalled while the result path has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid && snap_ready) |=> m_axis_tvalid)
    else $error("snapshot handed over but no result appeared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid && !snap_ready) |=> snap_valid && $stable(snap))
    else $error("held snapshot changed while the result stage was full");

endmodule
